// ===== design/mltdfa_pkg.sv =====
`default_nettype none

package mltdfa_pkg;

    localparam int LANES        = 8;
    localparam int MAX_STATES   = 256;
    localparam int MAX_SYMBOLS  = 256;
    localparam int TABLE_DEPTH  = MAX_STATES * MAX_SYMBOLS;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

    localparam int STATE_W      = 8;
    localparam int SYM_W        = 8;
    localparam int LANE_W       = 3;
    localparam int INDEX_W      = 16;
    localparam int COUNT_W      = 9;
    localparam int LEN_W        = 24;
    localparam int PROD_W       = SYM_W + COUNT_W;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOL_COUNT = 2'd0,
        REG_STATE_COUNT  = 2'd1,
        REG_TABLE_LAYOUT = 2'd2,
        REG_CHUNK_LENGTH = 2'd3
    } cfg_reg_t;

    typedef logic [STATE_W-1:0]  state_t;
    typedef logic [TABLE_AW-1:0] taddr_t;

endpackage

`default_nettype wire

// ===== design/multi_lane_table_dfa.sv =====
// pipeline: an accepted transaction is registered in stage 1, then its result in the output register
// throughput: one transaction per cycle unless out_stall holds the output, set by the
//   per-lane table ram read and the address multiply-add
// reset: lane states and step count clear to zero, registers take their defaults,
//   pipeline and output empty; transition table contents are undefined until written
`default_nettype none

module multi_lane_table_dfa
    import mltdfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            cmd,
    input  wire logic [INDEX_W-1:0]    table_index,
    input  wire logic [STATE_W-1:0]    value,
    input  wire logic [LANE_W-1:0]     lane,
    input  wire logic [SYM_W-1:0]      sym_lane0,
    input  wire logic [SYM_W-1:0]      sym_lane1,
    input  wire logic [SYM_W-1:0]      sym_lane2,
    input  wire logic [SYM_W-1:0]      sym_lane3,
    input  wire logic [SYM_W-1:0]      sym_lane4,
    input  wire logic [SYM_W-1:0]      sym_lane5,
    input  wire logic [SYM_W-1:0]      sym_lane6,
    input  wire logic [SYM_W-1:0]      sym_lane7,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATE_W-1:0]         lane_state0,
    output logic [STATE_W-1:0]         lane_state1,
    output logic [STATE_W-1:0]         lane_state2,
    output logic [STATE_W-1:0]         lane_state3,
    output logic [STATE_W-1:0]         lane_state4,
    output logic [STATE_W-1:0]         lane_state5,
    output logic [STATE_W-1:0]         lane_state6,
    output logic [STATE_W-1:0]         lane_state7,
    output logic                       chunk_done,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LEN_W-1:0]      cfg_data
);

    logic [COUNT_W-1:0] symbol_count_reg;
    logic [COUNT_W-1:0] state_count_reg;
    logic               table_layout_reg;
    logic [LEN_W-1:0]   chunk_length_reg;

    state_t             state_reg [LANES];
    logic [LEN_W-1:0]   step_count_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    cmd_t               s1_cmd_reg;
    state_t             s1_value_reg;
    logic [LANE_W-1:0]  s1_lane_reg;

    logic               out_valid_reg;
    state_t             out_state_reg [LANES];
    logic               out_done_reg;

    logic               in_acc;
    logic               s1_adv;
    logic               table_we;
    logic               step_re;
    cmd_t               in_cmd;

    logic [SYM_W-1:0]   sym [LANES];
    state_t             cur_state [LANES];
    state_t             rdata [LANES];
    logic [SYM_W-1:0]   mul_a [LANES];
    logic [COUNT_W-1:0] mul_b;
    logic [SYM_W-1:0]   add_c [LANES];
    logic [PROD_W-1:0]  addr_sum [LANES];
    taddr_t             raddr [LANES];
    logic [LEN_W-1:0]   count_cur;
    logic               done_cur;

    assign sym[0] = sym_lane0;
    assign sym[1] = sym_lane1;
    assign sym[2] = sym_lane2;
    assign sym[3] = sym_lane3;
    assign sym[4] = sym_lane4;
    assign sym[5] = sym_lane5;
    assign sym[6] = sym_lane6;
    assign sym[7] = sym_lane7;

    assign in_cmd    = cmd_t'(cmd);
    assign cfg_ready = 1'b1;

    // handshake
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = s1_valid_reg && out_valid_reg && out_stall;
    assign in_acc        = in_valid && !in_stall;
    assign s1_valid_next = in_acc || (s1_valid_reg && !s1_adv);

    assign table_we = in_acc && (in_cmd == CMD_WRITE)
                      && ({1'b0, table_index} < (INDEX_W+1)'(TABLE_DEPTH));
    assign step_re  = in_acc && (in_cmd == CMD_STEP);

    // lane states after every earlier transaction, forwarded from stage 1
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            cur_state[i] = state_reg[i];
            if (s1_valid_reg && (s1_cmd_reg == CMD_STEP))
            begin
                cur_state[i] = rdata[i];
            end
            else if (s1_valid_reg && (s1_cmd_reg == CMD_SET)
                     && (s1_lane_reg == LANE_W'(i)))
            begin
                cur_state[i] = s1_value_reg;
            end
        end
    end

    always_comb
    begin
        count_cur = step_count_reg;
        if (s1_valid_reg && (s1_cmd_reg == CMD_STEP))
        begin
            if (step_count_reg != '1)
            begin
                count_cur = step_count_reg + LEN_W'(1);
            end
        end
        else if (s1_valid_reg && (s1_cmd_reg == CMD_SET))
        begin
            count_cur = '0;
        end
        done_cur = (count_cur >= chunk_length_reg);
    end

    // lookup address: row * stride + column, wrapped to the table size
    assign mul_b = table_layout_reg ? state_count_reg : symbol_count_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mul_a[i]    = table_layout_reg ? sym[i] : cur_state[i];
            add_c[i]    = table_layout_reg ? cur_state[i] : sym[i];
            addr_sum[i] = ({{COUNT_W{1'b0}}, mul_a[i]} * {{SYM_W{1'b0}}, mul_b})
                          + {{COUNT_W{1'b0}}, add_c[i]};
            raddr[i]    = addr_sum[i][TABLE_AW-1:0];
        end
    end

    // one table copy per lane
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mltdfa_ram #(
            .WIDTH (STATE_W),
            .DEPTH (TABLE_DEPTH)
        ) u_table (
            .clk   (clk),
            .we    (table_we),
            .waddr (table_index[TABLE_AW-1:0]),
            .wdata (value),
            .re    (step_re),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= COUNT_W'(MAX_SYMBOLS);
            state_count_reg  <= COUNT_W'(MAX_STATES);
            table_layout_reg <= 1'b0;
            chunk_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[COUNT_W-1:0];
                REG_STATE_COUNT:  state_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_TABLE_LAYOUT: table_layout_reg <= cfg_data[0];
                REG_CHUNK_LENGTH: chunk_length_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_count_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                out_valid_reg  <= 1'b1;
                step_count_reg <= count_cur;
                for (int i = 0; i < LANES; i++)
                begin
                    state_reg[i] <= cur_state[i];
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_value_reg <= value;
            s1_lane_reg  <= lane;
        end
        if (s1_adv)
        begin
            out_done_reg <= done_cur;
            for (int i = 0; i < LANES; i++)
            begin
                out_state_reg[i] <= cur_state[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign chunk_done  = out_done_reg;
    assign lane_state0 = out_state_reg[0];
    assign lane_state1 = out_state_reg[1];
    assign lane_state2 = out_state_reg[2];
    assign lane_state3 = out_state_reg[3];
    assign lane_state4 = out_state_reg[4];
    assign lane_state5 = out_state_reg[5];
    assign lane_state6 = out_state_reg[6];
    assign lane_state7 = out_state_reg[7];

endmodule

`default_nettype wire

// ===== design/mltdfa_ram.sv =====
`default_nettype none

module mltdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== verif/multi_lane_table_dfa_test.sv =====
module multi_lane_table_dfa_test;
    import mltdfa_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASE_ITEMS     = 95;
    localparam int GAP_PERCENT     = 34;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [LANE_W-1:0]  lane_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;

    typedef struct packed {
        cmd_t                       op;
        index_t                     index;
        state_t                     val;
        lane_t                      lane_sel;
        logic [LANES-1:0][SYM_W-1:0] sym;
    } dfa_txn_t;

    typedef struct packed {
        logic [LANES-1:0][STATE_W-1:0] states;
        logic                          done;
    } lane_report_t;

    typedef struct packed {
        dfa_txn_t     txn;
        logic         typed;
        lane_report_t want;
    } script_row_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    logic   [1:0] cmd = 2'd0;
    index_t table_index = '0;
    state_t value = '0;
    lane_t  lane = '0;
    sym_t   sym_lane0 = '0;
    sym_t   sym_lane1 = '0;
    sym_t   sym_lane2 = '0;
    sym_t   sym_lane3 = '0;
    sym_t   sym_lane4 = '0;
    sym_t   sym_lane5 = '0;
    sym_t   sym_lane6 = '0;
    sym_t   sym_lane7 = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    state_t lane_state0;
    state_t lane_state1;
    state_t lane_state2;
    state_t lane_state3;
    state_t lane_state4;
    state_t lane_state5;
    state_t lane_state6;
    state_t lane_state7;
    logic   chunk_done;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic   [CFG_IDX_W-1:0] cfg_index = '0;
    len_t   cfg_data = '0;

    // automaton shadow
    state_t lane_now [LANES];
    len_t   steps_taken;
    count_t cfg_symbols;
    count_t cfg_states;
    logic   cfg_layout;
    len_t   cfg_chunk;
    state_t table_shadow [TABLE_DEPTH];
    bit     table_written [TABLE_DEPTH];

    lane_report_t pending_reports [$];
    lane_report_t seen;
    lane_report_t front;
    script_row_t  script [$];
    bit           no_gaps = 1'b0;
    int           errors = 0;
    int           idle_cycles = 0;

    multi_lane_table_dfa u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .table_index (table_index),
        .value       (value),
        .lane        (lane),
        .sym_lane0   (sym_lane0),
        .sym_lane1   (sym_lane1),
        .sym_lane2   (sym_lane2),
        .sym_lane3   (sym_lane3),
        .sym_lane4   (sym_lane4),
        .sym_lane5   (sym_lane5),
        .sym_lane6   (sym_lane6),
        .sym_lane7   (sym_lane7),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lane_state0 (lane_state0),
        .lane_state1 (lane_state1),
        .lane_state2 (lane_state2),
        .lane_state3 (lane_state3),
        .lane_state4 (lane_state4),
        .lane_state5 (lane_state5),
        .lane_state6 (lane_state6),
        .lane_state7 (lane_state7),
        .chunk_done  (chunk_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    assign seen = {lane_state7, lane_state6, lane_state5, lane_state4,
                   lane_state3, lane_state2, lane_state1, lane_state0, chunk_done};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    end

    function automatic taddr_t table_addr(state_t st, sym_t s);
        int unsigned full;
        if (cfg_layout)
            full = 32'(s) * 32'(cfg_states) + 32'(st);
        else
            full = 32'(st) * 32'(cfg_symbols) + 32'(s);
        return taddr_t'(full);
    endfunction

    task automatic advance_automaton(input dfa_txn_t t, output lane_report_t r);
        state_t nxt [LANES];
        case (t.op)
            CMD_WRITE:
            begin
                table_shadow[t.index] = t.val;
                table_written[t.index] = 1'b1;
            end
            CMD_SET:
            begin
                lane_now[t.lane_sel] = t.val;
                steps_taken = '0;
            end
            CMD_STEP:
            begin
                for (int i = 0; i < LANES; i++)
                    nxt[i] = table_shadow[table_addr(lane_now[i], t.sym[i])];
                for (int i = 0; i < LANES; i++)
                    lane_now[i] = nxt[i];
                if (steps_taken != '1)
                    steps_taken = steps_taken + 1'b1;
            end
            default: ;
        endcase
        for (int i = 0; i < LANES; i++)
            r.states[i] = lane_now[i];
        r.done = (steps_taken >= cfg_chunk);
    endtask

    function automatic dfa_txn_t random_txn();
        dfa_txn_t t;
        t.op = cmd_t'($urandom_range(0, 3));
        t.index = index_t'($urandom);
        t.val = state_t'($urandom);
        t.lane_sel = lane_t'($urandom);
        for (int i = 0; i < LANES; i++)
            t.sym[i] = sym_t'($urandom);
        return t;
    endfunction

    function automatic script_row_t plan_row(cmd_t op, index_t idx, state_t v, lane_t ln,
                                             logic [63:0] syms, logic typed,
                                             logic [63:0] want_states, logic want_done);
        script_row_t row;
        row.txn.op = op;
        row.txn.index = idx;
        row.txn.val = v;
        row.txn.lane_sel = ln;
        row.txn.sym = syms;
        row.typed = typed;
        row.want.states = want_states;
        row.want.done = want_done;
        return row;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic present_txn(input dfa_txn_t t, input logic typed, input lane_report_t want);
        lane_report_t r;
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd = t.op;
        table_index = t.index;
        value = t.val;
        lane = t.lane_sel;
        sym_lane0 = t.sym[0];
        sym_lane1 = t.sym[1];
        sym_lane2 = t.sym[2];
        sym_lane3 = t.sym[3];
        sym_lane4 = t.sym[4];
        sym_lane5 = t.sym[5];
        sym_lane6 = t.sym[6];
        sym_lane7 = t.sym[7];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        advance_automaton(t, r);
        pending_reports.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input len_t data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SYMBOL_COUNT: cfg_symbols = count_t'(data);
            REG_STATE_COUNT:  cfg_states = count_t'(data);
            REG_TABLE_LAYOUT: cfg_layout = data[0];
            REG_CHUNK_LENGTH: cfg_chunk = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic run_phase(input count_t sc, input count_t stc, input logic lay,
                             input len_t len, input bit steady, input bit pause_mid);
        dfa_txn_t t;
        dfa_txn_t w;
        taddr_t   a;
        int       ns;
        int       nsym;
        int       count;
        int       pick;
        bit       paused;
        write_cfg(REG_SYMBOL_COUNT, len_t'(sc));
        write_cfg(REG_STATE_COUNT, len_t'(stc));
        write_cfg(REG_TABLE_LAYOUT, len_t'(lay));
        write_cfg(REG_CHUNK_LENGTH, len);
        cfg_valid = 1'b0;
        no_gaps = steady;
        // working set of states and symbols kept small so the table fills quickly
        ns = (stc == 0) ? 4 : ((stc > 8) ? 8 : int'(stc));
        nsym = (sc == 0) ? 4 : ((sc > 8) ? 8 : int'(sc));
        paused = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            t = random_txn();
            t.op = CMD_SET;
            t.lane_sel = lane_t'(i);
            t.val = state_t'($urandom_range(0, ns - 1));
            present_txn(t, 1'b0, '0);
        end
        count = LANES;
        while (count < PHASE_ITEMS)
        begin
            t = random_txn();
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                t.op = CMD_STEP;
                for (int i = 0; i < LANES; i++)
                    if ($urandom_range(0, 9) != 0)
                        t.sym[i] = sym_t'($urandom_range(0, nsym - 1));
                // fill any entry this step would read before it is written
                for (int i = 0; i < LANES; i++)
                begin
                    a = table_addr(lane_now[i], t.sym[i]);
                    if (!table_written[a])
                    begin
                        w = random_txn();
                        w.op = CMD_WRITE;
                        w.index = a;
                        w.val = state_t'($urandom_range(0, ns - 1));
                        present_txn(w, 1'b0, '0);
                        count++;
                    end
                end
            end
            else if (pick < 70)
            begin
                t.op = CMD_SET;
                if ($urandom_range(0, 3) != 0)
                    t.val = state_t'($urandom_range(0, ns - 1));
            end
            else if (pick < 80)
                t.op = CMD_WRITE;
            else if (pick < 85)
                t.op = CMD_NOP;
            else
            begin
                t.op = CMD_WRITE;
                t.index = table_addr(state_t'($urandom_range(0, ns - 1)),
                                     sym_t'($urandom_range(0, nsym - 1)));
                t.val = state_t'($urandom_range(0, ns - 1));
            end
            present_txn(t, 1'b0, '0);
            if (t.op != CMD_NOP)
                count++;
            if (pause_mid && !paused && count >= PHASE_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result transaction, actual %h", $time, seen);
                errors++;
            end
            else
            begin
                front = pending_reports.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (seen.states[i] !== front.states[i])
                    begin
                        $display("%0t: lane_state%0d expected %h actual %h",
                                 $time, i, front.states[i], seen.states[i]);
                        errors++;
                    end
                if (seen.done !== front.done)
                begin
                    $display("%0t: chunk_done expected %b actual %b",
                             $time, front.done, seen.done);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("multi_lane_table_dfa verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < LANES; i++)
            lane_now[i] = '0;
        steps_taken = '0;
        cfg_symbols = count_t'(256);
        cfg_states = count_t'(256);
        cfg_layout = 1'b0;
        cfg_chunk = len_t'(1);
        for (int i = 0; i < TABLE_DEPTH; i++)
            table_written[i] = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default sizes, layout 0, chunk length 1
        script.push_back(plan_row(CMD_NOP, 16'hFFFF, 8'hFF, 3'd7, {8{8'hFF}},
                                  1'b1, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_SET, 16'h0000, 8'hFF, 3'd7, 64'h0,
                                  1'b1, 64'hFF00_0000_0000_0000, 1'b0));
        script.push_back(plan_row(CMD_SET, 16'hFFFF, 8'h00, 3'd0, {8{8'hFF}},
                                  1'b1, 64'hFF00_0000_0000_0000, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'hFFFF, 8'h12, 3'd0, 64'h0,
                                  1'b1, 64'hFF00_0000_0000_0000, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'h0000, 8'h34, 3'd7, {8{8'hFF}},
                                  1'b1, 64'hFF00_0000_0000_0000, 1'b0));
        script.push_back(plan_row(CMD_STEP, 16'h0000, 8'h00, 3'd0, 64'hFF00_0000_0000_0000,
                                  1'b1, 64'h1234_3434_3434_3434, 1'b1));
        script.push_back(plan_row(CMD_NOP, 16'h0000, 8'h00, 3'd0, 64'h0,
                                  1'b1, 64'h1234_3434_3434_3434, 1'b1));
        script.push_back(plan_row(CMD_WRITE, 16'h3400, 8'h01, 3'd2, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'h12FF, 8'hFE, 3'd5, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_STEP, 16'hAAAA, 8'h55, 3'd1, 64'hFF00_0000_0000_0000,
                                  1'b0, 64'h0, 1'b0));
        // setting a lane starts a new chunk
        script.push_back(plan_row(CMD_SET, 16'h5555, 8'h80, 3'd3, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'h8055, 8'hAA, 3'd4, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'h0155, 8'h55, 3'd6, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_WRITE, 16'hFE55, 8'h00, 3'd7, 64'h0,
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_STEP, 16'h0000, 8'hFF, 3'd0, {8{8'h55}},
                                  1'b0, 64'h0, 1'b0));
        script.push_back(plan_row(CMD_SET, 16'h0000, 8'hAA, 3'd5, {8{8'hAA}},
                                  1'b0, 64'h0, 1'b0));
        foreach (script[k])
            present_txn(script[k].txn, script[k].typed, script[k].want);
        drain_results();

        run_phase(count_t'(4), count_t'(4), 1'b0, len_t'(5), 1'b0, 1'b1);
        // chunk length zero keeps done high
        run_phase(count_t'(8), count_t'(3), 1'b1, len_t'(0), 1'b0, 1'b0);
        run_phase(count_t'(256), count_t'(256), 1'b0, len_t'(24'hFFFFFF), 1'b1, 1'b0);
        run_phase(count_t'(1), count_t'(1), 1'b1, len_t'(1), 1'b0, 1'b0);
        // strides wider than the table wrap the lookup address
        run_phase(count_t'(0), count_t'(511), 1'b1, len_t'(3), 1'b0, 1'b0);
        run_phase(count_t'(511), count_t'(0), 1'b0, len_t'(2), 1'b0, 1'b0);
        for (int p = 0; p < 4; p++)
            run_phase(count_t'($urandom_range(1, 16)), count_t'($urandom_range(1, 16)),
                      1'($urandom_range(0, 1)), len_t'($urandom_range(0, 40)), 1'b0, 1'b0);

        drain_results();
        if (errors == 0)
            $display("multi_lane_table_dfa verification clean");
        else
            $display("multi_lane_table_dfa verification failed");
        $finish;
    end

endmodule
